### rtl/max_window_sum_3x3_defines.svh
// ----------------------------------------------------------------------------
// max_window_sum_3x3 assertion macros
// shared property shorthands for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MAX_WINDOW_SUM_3X3_DEFINES_SVH
`define MAX_WINDOW_SUM_3X3_DEFINES_SVH

// same-cycle implication, reset masks the check
`define MWS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define MWS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mws_pkg.sv
// ----------------------------------------------------------------------------
// mws_pkg
// widths, register indexes and defaults shared by the window-sum search
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int WIN          = 3;
  localparam int WIN_CELLS    = WIN * WIN;
  localparam int CELL_IDX_W   = $clog2(WIN_CELLS);

  localparam int SAMPLE_W     = 16;
  localparam int COLSUM_W     = 18;
  localparam int SUM_W        = 20;
  localparam int POS_W        = 7;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;

  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_COUNT    = 128;

  // result payload: max_sum, top_row, left_col, element
  localparam int OUT_BITS     = SUM_W + 2 * POS_W + SAMPLE_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_t;

endpackage

### rtl/mws_line_buf.sv
// ----------------------------------------------------------------------------
// mws_line_buf
// one-row sample store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mws_line_buf
  import mws_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0]        wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0]        rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // read returns the old word when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/max_window_sum_3x3.sv
// ----------------------------------------------------------------------------
// max_window_sum_3x3
// result path: input register, then the snapshot, then the output bank
// throughput: one sample per cycle; nine results per frame, one per cycle
// while m_tready is high; a finished frame waits in a snapshot while the
// previous frame is sent; a frame's last sample stalls only while it is full
// reset: synchronous, dims back to 128 x 128, frame restarts, no clearing pass
// ----------------------------------------------------------------------------
`include "max_window_sum_3x3_defines.svh"

module max_window_sum_3x3
  import mws_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // sample stream in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
  // result stream out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] max_sum, [26:20] top_row,
                                            // [33:27] left_col, [49:34] element
  output logic                   m_tlast
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  // clamp a written dimension to 3..hi and return its last index
  function automatic int dim_last(input logic [CFG_W-1:0] v, input int hi);
    int n;
    n = int'(v);
    if (n < WIN) begin
      n = WIN;
    end else if (n > hi) begin
      n = hi;
    end
    return n - 1;
  endfunction

  // --------------------------------------------------------------------------
  // frame geometry and raster position
  // --------------------------------------------------------------------------
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;
  logic          accept;
  logic          pos_col_end;
  logic          pos_frame_end;

  // result staging state, declared early for the ready term
  logic                  snap_full;
  logic                  emit_busy;
  logic [CELL_IDX_W-1:0] emit_idx;

  assign pos_col_end   = (col_pos == col_last);
  assign pos_frame_end = pos_col_end && (row_pos == row_last);

  // only the frame's last sample has to wait for the result snapshot to free
  assign s_tready = !(pos_frame_end && snap_full);
  assign accept   = s_tvalid && s_tready;

  // a register write restarts the frame at the top-left
  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= RW'(dim_last(CFG_W'(DEF_COUNT), MAX_ROWS));
      col_last <= CW'(dim_last(CFG_W'(DEF_COUNT), MAX_COLS));
      row_pos  <= '0;
      col_pos  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          row_last <= RW'(dim_last(cfg_data, MAX_ROWS));
          row_pos  <= '0;
          col_pos  <= '0;
        end
        REG_COL_COUNT: begin
          col_last <= CW'(dim_last(cfg_data, MAX_COLS));
          row_pos  <= '0;
          col_pos  <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (pos_frame_end) begin
        row_pos <= '0;
        col_pos <= '0;
      end else if (pos_col_end) begin
        row_pos <= row_pos + 1'b1;
        col_pos <= '0;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // input register, line buffers read alongside
  // --------------------------------------------------------------------------
  logic                       pipe_valid;
  logic signed [SAMPLE_W-1:0] pipe_sample;
  logic [RW-1:0]              pipe_row;
  logic [CW-1:0]              pipe_col;
  logic                       pipe_row_ge1;
  logic                       pipe_row_ge2;
  logic                       pipe_full;
  logic                       pipe_last;
  logic [SAMPLE_W-1:0]        upper_rd;
  logic [SAMPLE_W-1:0]        lower_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pipe_sample  <= s_tdata[SAMPLE_W-1:0];
      pipe_row     <= row_pos;
      pipe_col     <= col_pos;
      pipe_row_ge1 <= (row_pos >= RW'(1));
      pipe_row_ge2 <= (row_pos >= RW'(2));
      pipe_full    <= (row_pos >= RW'(2)) && (col_pos >= CW'(2));
      pipe_last    <= pos_frame_end;
    end
  end

  // lower row takes the new sample; upper row takes what lower held, a cycle on
  mws_line_buf #(.DEPTH(MAX_COLS)) u_lower (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_pos),
    .wr_data (s_tdata[SAMPLE_W-1:0]),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (lower_rd)
  );

  mws_line_buf #(.DEPTH(MAX_COLS)) u_upper (
    .clk     (clk),
    .wr_en   (pipe_valid && pipe_row_ge1),
    .wr_addr (pipe_col),
    .wr_data (lower_rd),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (upper_rd)
  );

  // --------------------------------------------------------------------------
  // sliding window, column sums and best-window tracking
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] win [WIN][WIN-1];   // [row][col], older two columns
  logic signed [COLSUM_W-1:0] col_sum [WIN-1];
  logic signed [SAMPLE_W-1:0] new_col [WIN];      // top, mid, bottom
  logic signed [COLSUM_W-1:0] new_col_sum;
  logic signed [SUM_W-1:0]    win_sum;
  logic signed [SAMPLE_W-1:0] win_shifted [WIN_CELLS];
  logic                       take;

  logic                       have_best;
  logic signed [SUM_W-1:0]    best_sum;
  logic [RW-1:0]              best_row;
  logic [CW-1:0]              best_col;
  logic signed [SAMPLE_W-1:0] best_win [WIN_CELLS];

  always_comb begin
    new_col[0] = pipe_row_ge2 ? upper_rd : '0;
    new_col[1] = pipe_row_ge1 ? lower_rd : '0;
    new_col[2] = pipe_sample;
    new_col_sum = COLSUM_W'(new_col[0]) + COLSUM_W'(new_col[1])
                + COLSUM_W'(new_col[2]);
    win_sum = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(new_col_sum);
    for (int i = 0; i < WIN; i++) begin
      win_shifted[i*WIN]     = win[i][0];
      win_shifted[i*WIN + 1] = win[i][1];
      win_shifted[i*WIN + 2] = new_col[i];
    end
    // strictly greater keeps the first maximum in raster order
    take = pipe_valid && pipe_full && (!have_best || (win_sum > best_sum));
  end

  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      for (int i = 0; i < WIN; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= new_col[i];
      end
      col_sum[0] <= col_sum[1];
      col_sum[1] <= new_col_sum;
    end
    if (take) begin
      best_sum <= win_sum;
      best_row <= pipe_row - RW'(2);
      best_col <= pipe_col - CW'(2);
      best_win <= win_shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
      have_best <= 1'b0;
    end else if (pipe_valid && pipe_last) begin
      have_best <= 1'b0;
    end else if (take) begin
      have_best <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // result snapshot, output bank and emitter
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]    snap_sum;
  logic [POS_W-1:0]           snap_row;
  logic [POS_W-1:0]           snap_col;
  logic signed [SAMPLE_W-1:0] snap_win [WIN_CELLS];
  logic signed [SUM_W-1:0]    out_sum;
  logic [POS_W-1:0]           out_row;
  logic [POS_W-1:0]           out_col;
  logic signed [SAMPLE_W-1:0] out_win [WIN_CELLS];
  logic                       out_xfer;
  logic                       out_load;

  assign out_xfer = m_tvalid && m_tready;
  // snapshot moves out once the output bank is empty or sends its ninth transfer
  assign out_load = snap_full && (!emit_busy || (out_xfer && m_tlast));

  // snapshot takes the frame's last window into account
  always_ff @(posedge clk) begin
    if (pipe_valid && pipe_last) begin
      if (take) begin
        snap_sum <= win_sum;
        snap_row <= POS_W'(pipe_row - RW'(2));
        snap_col <= POS_W'(pipe_col - CW'(2));
        snap_win <= win_shifted;
      end else begin
        snap_sum <= best_sum;
        snap_row <= POS_W'(best_row);
        snap_col <= POS_W'(best_col);
        snap_win <= best_win;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_full <= 1'b0;
    end else if (pipe_valid && pipe_last) begin
      snap_full <= 1'b1;
    end else if (out_load) begin
      snap_full <= 1'b0;
    end
  end

  // output bank shifts one element down per transfer
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum <= snap_sum;
      out_row <= snap_row;
      out_col <= snap_col;
      out_win <= snap_win;
    end else if (out_xfer) begin
      for (int k = 0; k < WIN_CELLS - 1; k++) begin
        out_win[k] <= out_win[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
    end else if (out_load) begin
      emit_busy <= 1'b1;
      emit_idx  <= '0;
    end else if (out_xfer) begin
      if (emit_idx == CELL_IDX_W'(WIN_CELLS - 1)) begin
        emit_busy <= 1'b0;
        emit_idx  <= '0;
      end else begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  assign m_tvalid = emit_busy;
  assign m_tlast  = (emit_idx == CELL_IDX_W'(WIN_CELLS - 1));
  assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), out_win[0], out_col, out_row,
                     out_sum};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `MWS_ASSERT_IMP(a_snap_free, clk, rst, pipe_valid && pipe_last, !snap_full,
    "frame ended while the result snapshot was still occupied")
  `MWS_ASSERT_NXT(a_emit_start, clk, rst, out_load,
    m_tvalid && (emit_idx == '0), "results did not start after snapshot move")
  `MWS_ASSERT_NXT(a_emit_stop, clk, rst, out_xfer && m_tlast, emit_idx == '0,
    "result count did not wrap after the ninth transfer")
  `MWS_ASSERT_IMP(a_pos_range, clk, rst, 1'b1,
    (col_pos <= col_last) && (row_pos <= row_last), "raster position out of range")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// max_window_sum_3x3 testbench
// streams matrices through the block and checks the nine best-window results
// of every frame against a behavioural copy of the 3x3 box-sum search, under
// random gaps and stalls on both streams and a range of matrix sizes
// ----------------------------------------------------------------------------
module testbench;
  import mws_pkg::*;

  // one result as it leaves the block, tlast on top of the packed payload
  typedef struct packed {
    logic                       last;
    logic signed [SAMPLE_W-1:0] element;
    logic [POS_W-1:0]           left_col;
    logic [POS_W-1:0]           top_row;
    logic signed [SUM_W-1:0]    max_sum;
  } window_cell_t;

  // kinds of matrix content
  typedef enum int {FILL_ANY, FILL_TIES, FILL_EXTREMES, FILL_HIGH, FILL_MAX, FILL_MIN} fill_t;

  // --------------------------------------------------------------------------
  // behavioural copy of the search plus the queue of cells still owed
  // --------------------------------------------------------------------------
  class max_window_tracker;
    logic [CFG_W-1:0]           row_count, col_count;
    logic signed [SAMPLE_W-1:0] upper_line[DEF_MAX_COLS];
    logic signed [SAMPLE_W-1:0] lower_line[DEF_MAX_COLS];
    logic signed [SAMPLE_W-1:0] window[WIN][WIN];
    logic signed [SAMPLE_W-1:0] best_window[WIN][WIN];
    int                         row_at, col_at;
    int                         best_sum, best_row, best_col;
    bit                         have_best;
    window_cell_t               pending_cells[$];
    int                         mismatches, cells_seen, samples_seen, frames_done;

    function new();
      row_count = DEF_COUNT;
      col_count = DEF_COUNT;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (window[i, j]) begin
        window[i][j]      = '0;
        best_window[i][j] = '0;
      end
      best_sum = 0;
      best_row = 0;
      best_col = 0;
      restart();
    endfunction

    function void restart();
      row_at    = 0;
      col_at    = 0;
      have_best = 1'b0;
    endfunction

    function int span(int v, int hi);
      if (v < WIN) return WIN;
      if (v > hi) return hi;
      return v;
    endfunction

    function int rows_used();
      return span(row_count, DEF_MAX_ROWS);
    endfunction

    function int cols_used();
      return span(col_count, DEF_MAX_COLS);
    endfunction

    // any register write restarts the frame
    function void set_dim(cfg_reg_t idx, logic [CFG_W-1:0] v);
      if (idx == REG_ROW_COUNT) begin
        row_count = v;
      end else begin
        col_count = v;
      end
      restart();
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int rows, cols, r, c, sum, i, j;
      logic signed [SAMPLE_W-1:0] top, mid;
      window_cell_t owed;
      rows = rows_used();
      cols = cols_used();
      r    = row_at;
      c    = col_at;
      if (c >= cols) c = cols - 1;
      if (r >= rows) r = rows - 1;
      top = '0;
      mid = '0;
      samples_seen++;
      // column above this sample, then shift the line buffers down
      if (r >= 2) top = upper_line[c];
      if (r >= 1) begin
        mid           = lower_line[c];
        upper_line[c] = mid;
      end
      lower_line[c] = s;
      for (i = 0; i < WIN; i++) begin
        window[i][0] = window[i][1];
        window[i][1] = window[i][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = s;
      // full window: keep it if first of the frame or strictly larger
      if (r >= 2 && c >= 2) begin
        sum = 0;
        for (i = 0; i < WIN; i++)
          for (j = 0; j < WIN; j++)
            sum += window[i][j];
        if (!have_best || sum > best_sum) begin
          have_best   = 1'b1;
          best_sum    = sum;
          best_row    = r - 2;
          best_col    = c - 2;
          best_window = window;
        end
      end
      if (r == rows - 1 && c == cols - 1) begin
        for (i = 0; i < WIN; i++) begin
          for (j = 0; j < WIN; j++) begin
            owed.max_sum  = best_sum[SUM_W-1:0];
            owed.top_row  = best_row[POS_W-1:0];
            owed.left_col = best_col[POS_W-1:0];
            owed.element  = best_window[i][j];
            owed.last     = (i == WIN - 1 && j == WIN - 1);
            pending_cells.push_back(owed);
          end
        end
        frames_done++;
        restart();
        return;
      end
      if (c + 1 >= cols) begin
        col_at = 0;
        row_at = r + 1;
      end else begin
        col_at = c + 1;
        row_at = r;
      end
    endfunction

    function void complain(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
      window_cell_t got, want;
      got = {tlast, data[OUT_BITS-1:0]};
      cells_seen++;
      if (pending_cells.size() == 0) begin
        complain($sformatf("result with nothing pending, payload %h", got));
        return;
      end
      want = pending_cells.pop_front();
      if (got.max_sum !== want.max_sum)
        complain($sformatf("max_sum expected %0d, got %0d", want.max_sum, got.max_sum));
      if (got.top_row !== want.top_row)
        complain($sformatf("top_row expected %0d, got %0d", want.top_row, got.top_row));
      if (got.left_col !== want.left_col)
        complain($sformatf("left_col expected %0d, got %0d", want.left_col, got.left_col));
      if (got.element !== want.element)
        complain($sformatf("element expected %0d, got %0d", want.element, got.element));
      if (got.last !== want.last)
        complain($sformatf("tlast expected %0b, got %0b", want.last, got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [19:0] max_sum, [26:20] top_row,
                                     // [33:27] left_col, [49:34] element
  logic                   m_tlast;

  max_window_sum_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  max_window_tracker board = new();

  // idling controls for the sender and the receiver
  bit sender_calm   = 1'b0;  // no gaps between sample transfers
  bit receiver_calm = 1'b0;  // no stalls on the result side
  int ready_hold    = 0;     // long receiver hold-off, counted down per cycle
  int stall_left    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $display("run timed out with %0d results outstanding", board.pending_cells.size());
    $finish;
  end

  // mostly back-to-back, sometimes a short gap, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // register values: mostly small frames, some below the floor, a few wider
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(3, 6);
    if (r < 9) return $urandom_range(0, 2);
    return $urandom_range(7, 12);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_t mode);
    case (mode)
      FILL_TIES:     return SAMPLE_W'(int'($urandom_range(0, 4)) - 2);
      FILL_EXTREMES: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      FILL_HIGH:     return SAMPLE_W'(32'sh7fff - int'($urandom_range(0, 15)));
      FILL_MAX:      return 16'sh7fff;
      FILL_MIN:      return 16'sh8000;
      default:       return SAMPLE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls, the long hold-off, and the check on transfer
  // --------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (ready_hold > 0) begin
        // held off long enough for the block to fill and stall its input
        m_tready <= 1'b0;
        ready_hold--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!receiver_calm) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.match_result(m_tdata, m_tlast);
  end

  // --------------------------------------------------------------------------
  // sample side
  // --------------------------------------------------------------------------
  // valid stays high from one sample to the next unless a gap is inserted
  task automatic send_sample(logic signed [SAMPLE_W-1:0] v);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    board.take_sample(v);
  endtask

  task automatic sender_gap(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= IN_TDATA_W'($urandom);
    end
  endtask

  task automatic run_samples(int n, fill_t mode);
    repeat (n) begin
      if (!sender_calm) sender_gap(idle_len());
      send_sample(pick_sample(mode));
    end
  endtask

  task automatic run_frame(fill_t mode);
    run_samples(board.rows_used() * board.cols_used(), mode);
  endtask

  // sender pauses until every owed result has arrived, then lets the
  // pipeline settle past its latency
  task automatic drain();
    sender_gap(1);
    while (board.pending_cells.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_dim(cfg_reg_t idx, int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_dim(idx, v[CFG_W-1:0]);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int    base;
    int    rr, cc;
    fill_t mode;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // a frame at the reset size cut short by a register write, which restarts it
    run_samples(5, FILL_ANY);
    drain();

    // register values below the floor act as 3: all-maximum window
    write_dim(REG_ROW_COUNT, 0);
    write_dim(REG_COL_COUNT, 2);
    run_frame(FILL_MAX);
    drain();

    // 3 x 4 of the most negative sample: equal sums, first window must stay
    write_dim(REG_ROW_COUNT, 1);
    write_dim(REG_COL_COUNT, 4);
    run_frame(FILL_MIN);
    drain();

    // smallest frames with the receiver held off while samples keep coming,
    // so a later frame's last sample has to wait for the drain
    write_dim(REG_ROW_COUNT, 3);
    write_dim(REG_COL_COUNT, 3);
    ready_hold  = 250;
    sender_calm = 1'b1;
    repeat (4) run_frame(FILL_ANY);
    sender_calm = 1'b0;
    drain();

    // random frames: sizes change only between drained frames, otherwise
    // frames follow each other while the previous results are still leaving
    base = board.samples_seen;
    while (board.samples_seen - base < 150) begin
      if ($urandom_range(0, 9) < 6) begin
        drain();
        rr = pick_dim();
        cc = pick_dim();
        if ($urandom_range(0, 1)) begin
          write_dim(REG_ROW_COUNT, rr);
          write_dim(REG_COL_COUNT, cc);
        end else begin
          write_dim(REG_COL_COUNT, cc);
          write_dim(REG_ROW_COUNT, rr);
        end
      end
      sender_calm   = ($urandom_range(0, 4) == 0);
      receiver_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0, 1:    mode = FILL_ANY;
        2, 3:    mode = FILL_TIES;
        4:       mode = FILL_EXTREMES;
        default: mode = FILL_HIGH;
      endcase
      run_frame(mode);
    end

    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    drain();

    $display("%0d frames, %0d samples and %0d results went through the block",
             board.frames_done, board.samples_seen, board.cells_seen);
    $display("frames 3 x 3 to 12 x 12, undersized register values, ties, extremes, restart");
    if (board.pending_cells.size() != 0)
      $display("%0d results never arrived", board.pending_cells.size());
    if (board.mismatches == 0 && board.pending_cells.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### max_window_sum_3x3.f
+incdir+rtl
rtl/mws_pkg.sv
rtl/mws_line_buf.sv
rtl/max_window_sum_3x3.sv
sim/testbench.sv
